FILE: rtl/fpa_pkg.sv
// Shared constants and types for the fixed-point arithmetic unit.
// Holds the operation codes, the fraction width and the divider pipeline sizing.
// No dependencies.
package fpa_pkg;

  // Number of fraction bits in the fixed-point format.
  localparam int FRAC_BITS = 8;

  // Operation codes carried on the kind field.
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_MUL     = 4'd2;
  localparam logic [3:0] OP_DIV     = 4'd3;
  localparam logic [3:0] OP_INC     = 4'd4;
  localparam logic [3:0] OP_DEC     = 4'd5;
  localparam logic [3:0] OP_CMP     = 4'd6;
  localparam logic [3:0] OP_MIN     = 4'd7;
  localparam logic [3:0] OP_MAX     = 4'd8;
  localparam logic [3:0] OP_INT2FIX = 4'd9;
  localparam logic [3:0] OP_FIX2INT = 4'd10;
  localparam logic [3:0] OP_FLT2FIX = 4'd11;
  localparam logic [3:0] OP_FIX2FLT = 4'd12;

  // Divider sizing: quotient bits resolved per stage and the number of stages.
  localparam int DIV_BPS    = 4;
  localparam int DIV_W      = 32 + FRAC_BITS;
  localparam int DIV_STAGES = (DIV_W + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_PW     = DIV_STAGES * DIV_BPS;

  // Side stages that follow the four float stages until the divider finishes.
  localparam int SIDE_DLY = DIV_STAGES - 3;

  // Per-item payload that travels beside the divider.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        err;
    logic        neg;
    logic        dz;
  } side_t;

endpackage

FILE: rtl/fpa_div.sv
// Pipelined restoring divider on unsigned magnitudes for the fixed-point unit.
// The dividend is the magnitude shifted left by the fraction width.
// Depends on fpa_pkg.
module fpa_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] dvd_mag,
  input  logic [31:0] dsr_mag,
  output logic [31:0] quo
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [32:0]       rem;
    logic [DIV_PW-1:0] dvd;
    logic [31:0]       quo;
    logic [31:0]       dsr;
  } div_st_t;

  div_st_t st [DIV_STAGES];
  div_st_t init;

  // The first stage starts from a zero remainder with the scaled dividend.
  always_comb begin
    init.rem = '0;
    init.dvd = DIV_PW'({dvd_mag, {FRAC_BITS{1'b0}}});
    init.quo = '0;
    init.dsr = dsr_mag;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    div_st_t src;
    div_st_t nxt;

    if (j == 0) begin : g_first
      assign src = init;
    end else begin : g_rest
      assign src = st[j-1];
    end

    // Each stage resolves a few quotient bits, one trial subtract per bit.
    always_comb begin
      logic [32:0] r;
      logic        qb;
      nxt = src;
      for (int k = 0; k < DIV_BPS; k++) begin
        r       = {nxt.rem[31:0], nxt.dvd[DIV_PW-1]};
        nxt.dvd = {nxt.dvd[DIV_PW-2:0], 1'b0};
        qb      = (r >= {1'b0, nxt.dsr});
        if (qb) begin
          r = r - {1'b0, nxt.dsr};
        end
        nxt.rem = r;
        nxt.quo = {nxt.quo[30:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nxt;
      end
    end
  end

  assign quo = st[DIV_STAGES-1].quo;

endmodule

FILE: rtl/fixed_point_alu.sv
// Top level of the signed 32-bit fixed-point arithmetic unit.
// Depends on fpa_pkg and on the pipelined divider fpa_div.
//
// Usage: an item (kind, operand_a, operand_b) is taken on in_valid when
// in_stall is low, and one result (value and four flags) leaves on out_valid,
// held until out_stall is low.
// Every operation passes through the same stages; the depth is set by the
// divider, which resolves four quotient bits per stage. Shorter operations
// ride along in the same pipeline so results leave in order.
// One item per cycle unless the output stalls; the pipeline advances as one.
// When the receiver stalls a waiting result, every stage holds and in_stall
// rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset. The unit keeps
// no state between items.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic        is_less,
  output logic        is_equal,
  output logic        is_greater,
  output logic        error
);
  import fpa_pkg::*;

  logic adv;

  // Stage A registers.
  side_t              sa;
  logic               va;
  logic signed [63:0] a_prod;
  logic [31:0]        a_ma;
  logic [31:0]        a_mb;
  logic [31:0]        a_raw;
  side_t              sa_next;

  // Stage B registers.
  side_t       sb;
  logic        vb;
  logic [33:0] b_mag;
  logic        b_fsign;
  logic        b_nan;
  logic        b_inf;
  logic [4:0]  b_p;
  logic [31:0] b_ma;
  logic        b_zero;
  side_t       sb_next;
  logic [33:0] b_mag_next;
  logic [4:0]  b_p_next;
  logic        b_zero_next;

  // Stage C registers.
  side_t       sc;
  logic        vc;
  logic [31:0] c_nm;
  logic [4:0]  c_p;
  logic        c_zero;
  logic        c_sign;
  side_t       sc_next;

  // Stage D and the delay line.
  side_t sd;
  logic  vd;
  side_t sd_next;
  side_t dly [SIDE_DLY];
  logic  vdly [SIDE_DLY];

  logic [31:0] quo;

  // The pipeline moves unless a finished result is waiting on the receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: simple operations, the product, and operand magnitudes.
  always_comb begin
    logic signed [31:0] sa_op;
    logic signed [31:0] sb_op;
    sa_op = operand_a;
    sb_op = operand_b;
    sa_next      = '0;
    sa_next.kind = kind;
    sa_next.neg  = operand_a[31] ^ operand_b[31];
    sa_next.dz   = (operand_b == 32'd0);
    case (kind)
      OP_ADD:     sa_next.res = operand_a + operand_b;
      OP_SUB:     sa_next.res = operand_a - operand_b;
      OP_INC:     sa_next.res = operand_a + 32'd1;
      OP_DEC:     sa_next.res = operand_a - 32'd1;
      OP_CMP: begin
        sa_next.lt = (sa_op < sb_op);
        sa_next.eq = (sa_op == sb_op);
        sa_next.gt = (sa_op > sb_op);
      end
      OP_MIN:     sa_next.res = (sa_op < sb_op) ? operand_a : operand_b;
      OP_MAX:     sa_next.res = (sa_op > sb_op) ? operand_a : operand_b;
      OP_INT2FIX: sa_next.res = operand_a << FRAC_BITS;
      OP_FIX2INT: sa_next.res = 32'(sa_op >>> FRAC_BITS);
      default:    sa_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa     <= sa_next;
      a_prod <= $signed(operand_a) * $signed(operand_b);
      a_ma   <= operand_a[31] ? (32'd0 - operand_a) : operand_a;
      a_mb   <= operand_b[31] ? (32'd0 - operand_b) : operand_b;
      a_raw  <= operand_a;
    end
  end

  fpa_div u_div (
    .clk     (clk),
    .adv     (adv),
    .dvd_mag (a_ma),
    .dsr_mag (a_mb),
    .quo     (quo)
  );

  // Stage B: product scaling, float unpack and scale, leading one search.
  always_comb begin
    logic [7:0]        ex;
    logic [7:0]        ex_eff;
    logic [23:0]       man;
    logic signed [9:0] sh;
    logic [9:0]        k;
    logic [25:0]       t;
    ex     = a_raw[30:23];
    ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    man    = {(ex != 8'd0), a_raw[22:0]};
    sh     = $signed({2'b00, ex_eff}) - 10'sd150 + $signed(10'(FRAC_BITS));
    k      = 10'd0 - sh;
    t      = '0;
    if (!sh[9]) begin
      if (sh > 10'sd8) begin
        b_mag_next = 34'h2_0000_0000;
      end else begin
        b_mag_next = 34'(man) << sh[3:0];
      end
    end else if (k > 10'd25) begin
      b_mag_next = '0;
    end else begin
      t          = 26'(man) + (26'd1 << (k[4:0] - 5'd1));
      b_mag_next = 34'(t >> k[4:0]);
    end

    b_p_next    = '0;
    b_zero_next = (a_ma == 32'd0);
    for (int i = 0; i < 32; i++) begin
      if (a_ma[i]) begin
        b_p_next = 5'(i);
      end
    end

    sb_next = sa;
    if (sa.kind == OP_MUL) begin
      sb_next.res = 32'(a_prod >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb      <= sb_next;
      b_mag   <= b_mag_next;
      b_fsign <= a_raw[31];
      b_nan   <= (a_raw[30:23] == 8'hFF) && (a_raw[22:0] != 23'd0);
      b_inf   <= (a_raw[30:23] == 8'hFF) && (a_raw[22:0] == 23'd0);
      b_p     <= b_p_next;
      b_ma    <= a_ma;
      b_zero  <= b_zero_next;
    end
  end

  // Stage C: float to fixed saturation and sign, normalize the fixed magnitude.
  always_comb begin
    sc_next = sb;
    if (sb.kind == OP_FLT2FIX) begin
      if (b_nan) begin
        sc_next.res = '0;
        sc_next.err = 1'b1;
      end else if (b_inf) begin
        sc_next.res = b_fsign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sc_next.err = 1'b1;
      end else if (b_fsign) begin
        if (b_mag > 34'h0_8000_0000) begin
          sc_next.res = 32'h8000_0000;
          sc_next.err = 1'b1;
        end else begin
          sc_next.res = 32'd0 - b_mag[31:0];
        end
      end else if (b_mag > 34'h0_7FFF_FFFF) begin
        sc_next.res = 32'h7FFF_FFFF;
        sc_next.err = 1'b1;
      end else begin
        sc_next.res = b_mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc     <= sc_next;
      c_nm   <= b_ma << (5'd31 - b_p);
      c_p    <= b_p;
      c_zero <= b_zero;
      c_sign <= b_fsign;
    end
  end

  // Stage D: round the normalized magnitude to nearest even and pack.
  always_comb begin
    logic       rnd;
    logic [24:0] sum;
    logic [8:0] expo;
    logic [22:0] mant;
    rnd  = c_nm[7] && ((c_nm[6:0] != 7'd0) || c_nm[8]);
    sum  = {1'b0, c_nm[31:8]} + 25'(rnd);
    expo = 9'(c_p) + 9'd127 - 9'(FRAC_BITS) + 9'(sum[24]);
    mant = sum[24] ? sum[23:1] : sum[22:0];
    sd_next = sc;
    if (sc.kind == OP_FIX2FLT) begin
      sd_next.res = c_zero ? 32'd0 : {c_sign, expo[7:0], mant};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd <= sd_next;
    end
  end

  // Delay line that keeps the side payload aligned with the divider output.
  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= sd;
      for (int i = 1; i < SIDE_DLY; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < SIDE_DLY; i++) begin
        vdly[i] <= 1'b0;
      end
    end else if (adv) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      vdly[0]   <= vd;
      for (int i = 1; i < SIDE_DLY; i++) begin
        vdly[i] <= vdly[i-1];
      end
      out_valid <= vdly[SIDE_DLY-1];
    end
  end

  // Output stage: apply the divider sign and the divide-by-zero case.
  always_ff @(posedge clk) begin
    if (adv) begin
      is_less    <= dly[SIDE_DLY-1].lt;
      is_equal   <= dly[SIDE_DLY-1].eq;
      is_greater <= dly[SIDE_DLY-1].gt;
      if (dly[SIDE_DLY-1].kind == OP_DIV) begin
        error <= dly[SIDE_DLY-1].dz;
        if (dly[SIDE_DLY-1].dz) begin
          value <= '0;
        end else begin
          value <= dly[SIDE_DLY-1].neg ? (32'd0 - quo) : quo;
        end
      end else begin
        error <= dly[SIDE_DLY-1].err;
        value <= dly[SIDE_DLY-1].res;
      end
    end
  end

`ifndef SYNTHESIS
  // An error result is always zero or a saturation value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |->
      (value == 32'd0) || (value == 32'h7FFF_FFFF) || (value == 32'h8000_0000))
    else $error("error flag with a value that is neither zero nor saturated");

  // Compare flags are exclusive and come with a zero value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_less || is_equal || is_greater) |->
      $onehot({is_less, is_equal, is_greater}) && (value == 32'd0) && !error)
    else $error("compare flags not exclusive or value not zero");

  // A stalled output holds the whole pipeline still.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vd) && $stable(va))
    else $error("pipeline advanced while the output was stalled");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the fixed-point arithmetic unit fixed_point_alu.
// Depends on fpa_pkg for operation codes and FRAC_BITS; predicts each result
// in plain SystemVerilog and checks results in order.
`timescale 1ns / 1ps

module tb;
  import fpa_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        err;
  } alu_result_t;

  // In-order store of predicted results, with mismatch accounting.
  class alu_scoreboard;
    alu_result_t pending[$];
    int          mismatches;

    // Signed shift right of a 64-bit value by FRAC_BITS, low 32 bits kept.
    function automatic logic [31:0] shift_down(logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      return s[31:0];
    endfunction

    // Float bit pattern to fixed, rounding half away from zero.
    function automatic logic [31:0] float_to_fixed(logic [31:0] f, output logic err);
      logic [63:0] man;
      logic [63:0] mag;
      int          sh;
      int          k;
      err = 1'b0;
      man = {41'd0, f[22:0]};
      if (f[30:23] == 8'hFF) begin
        err = 1'b1;
        if (man != 0) return 32'd0;
        return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (f[30:23] == 8'd0) sh = -149 + FRAC_BITS;
      else begin
        man = man | 64'h80_0000;
        sh = int'(f[30:23]) - 150 + FRAC_BITS;
      end
      if (man == 0) return 32'd0;
      if (sh >= 0) mag = (sh > 39) ? (64'd1 << 40) : (man << sh);
      else begin
        k = -sh;
        mag = (k > 25) ? 64'd0 : ((man + (64'd1 << (k - 1))) >> k);
      end
      if (f[31]) begin
        if (mag > 64'h8000_0000) begin
          err = 1'b1;
          return 32'h8000_0000;
        end
        return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
        err = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    endfunction

    // Fixed raw value to float, round to nearest even.
    function automatic logic [31:0] fixed_to_float(logic signed [31:0] raw);
      logic [63:0] mag;
      logic [63:0] frac;
      logic [63:0] half;
      logic [63:0] rem;
      logic [7:0]  ex;
      int          msb;
      int          r;
      mag = raw[31] ? 64'd0 - {{32{raw[31]}}, raw} : {32'd0, raw};
      if (mag == 0) return 32'd0;
      msb = 0;
      while ((mag >> (msb + 1)) != 0) msb++;
      if (msb <= 23) frac = mag << (23 - msb);
      else begin
        r = msb - 23;
        half = 64'd1 << (r - 1);
        rem = mag & ((64'd1 << r) - 1);
        frac = mag >> r;
        if (rem > half || (rem == half && frac[0])) frac++;
        if (frac[24]) begin
          frac = frac >> 1;
          msb++;
        end
      end
      ex = 8'(msb - FRAC_BITS + 127);
      return {raw[31], ex, frac[22:0]};
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      alu_result_t r;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] q;
      logic        e;
      r = '{32'd0, 1'b0, 1'b0, 1'b0, 1'b0};
      case (op)
        OP_ADD: r.value = a + b;
        OP_SUB: r.value = a - b;
        OP_MUL: r.value = shift_down(64'(a) * 64'(b));
        OP_DIV: begin
          if (b == 0) r.err = 1'b1;
          else begin
            ma = a[31] ? 64'd0 - 64'(a) : 64'(a);
            mb = b[31] ? 64'd0 - 64'(b) : 64'(b);
            q = (ma << FRAC_BITS) / mb;
            r.value = (a[31] != b[31]) ? 32'd0 - q[31:0] : q[31:0];
          end
        end
        OP_INC: r.value = a + 1;
        OP_DEC: r.value = a - 1;
        OP_CMP: begin
          r.lt = a < b;
          r.eq = a == b;
          r.gt = a > b;
        end
        OP_MIN: r.value = (a < b) ? a : b;
        OP_MAX: r.value = (a > b) ? a : b;
        OP_INT2FIX: r.value = a << FRAC_BITS;
        OP_FIX2INT: r.value = shift_down(64'(a));
        OP_FLT2FIX: begin
          r.value = float_to_fixed(a, e);
          r.err = e;
        end
        OP_FIX2FLT: r.value = fixed_to_float(a);
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(alu_result_t got);
      alu_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: value %h", got.value);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.lt !== want.lt || got.eq !== want.eq ||
          got.gt !== want.gt || got.err !== want.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h l%b e%b g%b err%b, got %h l%b e%b g%b err%b",
                   want.value, want.lt, want.eq, want.gt, want.err,
                   got.value, got.lt, got.eq, got.gt, got.err);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  kind = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] value;
  logic        is_less;
  logic        is_equal;
  logic        is_greater;
  logic        error;

  alu_scoreboard results = new();
  bit            sending_done = 1'b0;
  int            stall_left = 0;

  always #5 clk = ~clk;

  fixed_point_alu uut (.*);

  // Random gap length: mostly short, a few long, sometimes none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random operand biased toward corner values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2) - 1;
      3: return $urandom_range(0, 4095) - 2048;
      default: return $urandom();
    endcase
  endfunction

  // Random float pattern covering specials, subnormals and the useful range.
  function automatic logic [31:0] pick_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'hFF;
      1: f[30:23] = 8'h00;
      2: f[30:23] = 8'($urandom_range(100, 160));
      default: f[30:23] = 8'($urandom_range(110, 155));
    endcase
    return f;
  endfunction

  // Sends one item and waits until it is accepted.
  task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    kind <= op;
    operand_a <= a;
    operand_b <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results.note_item(op, a, b);
  endtask

  // Lowers valid for a random gap after an item.
  task automatic idle_sender();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [3:0] op;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items: field extremes, each operation and the special cases.
    send_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_item(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_MUL, 32'h8000_0000, 32'hFFFF_FF00);
    send_item(OP_DIV, 32'h0000_0100, 32'h0000_0000);
    send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_DIV, 32'hFFFF_FD00, 32'h0000_0200);
    send_item(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_DEC, 32'h8000_0000, 32'h0);
    send_item(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_CMP, 32'h1234_5678, 32'h1234_5678);
    send_item(OP_MIN, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_MAX, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_INT2FIX, 32'h00FF_FFFF, 32'h0);
    send_item(OP_FIX2INT, 32'hFFFF_FF01, 32'h0);
    send_item(OP_FLT2FIX, 32'h7FC0_0000, 32'h0);
    send_item(OP_FLT2FIX, 32'hFF80_0000, 32'h0);
    send_item(OP_FLT2FIX, 32'h4F00_0000, 32'h0);
    send_item(OP_FLT2FIX, 32'hCB00_0000, 32'h0);
    send_item(OP_FLT2FIX, 32'h8000_0000, 32'h0);
    send_item(OP_FLT2FIX, 32'h3BC0_0000, 32'h0);
    send_item(OP_FLT2FIX, 32'h0000_0001, 32'h0);
    send_item(OP_FIX2FLT, 32'h8000_0000, 32'h0);
    send_item(OP_FIX2FLT, 32'h7FFF_FFFF, 32'h0);
    send_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random items over every code, with corner-biased operands.
    for (int i = 0; i < 1400; i++) begin
      if ($urandom_range(0, 39) == 0) op = 4'($urandom_range(13, 15));
      else op = 4'($urandom_range(0, 12));
      send_item(op, (op == OP_FLT2FIX) ? pick_float() : pick_operand(),
                ($urandom_range(0, 7) == 0) ? 32'd0 : pick_operand());
      if ($urandom_range(0, 3) == 0) idle_sender();
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: stall stretches of random length, mostly short and a few long.
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      results.check_result('{value, is_less, is_equal, is_greater, error});
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // End of run once every prediction is matched and the pipeline drains.
  initial begin
    wait (sending_done);
    while (results.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (results.mismatches == 0 && results.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
